// File: hw/rtl/rtpn_pkg.sv
// Shared types and constants for the note journal chapter block.
// Depends on nothing; every other file of the block imports it.
package rtpn_pkg;

    localparam int CNT_W = 8;               // holds a count up to 255
    localparam logic [7:0] LOG_MARK = 8'h80;
    localparam logic [3:0] NO_LOW = 4'd15;
    localparam logic [3:0] CHUNK_FULL = 4'd8;
    localparam logic [6:0] LEN_MAX = 7'd127;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_RESET    = 2'd2,
        OP_BUILD    = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  pitch;
        logic [6:0]  velocity;
        logic [31:0] current_payload;
        logic [31:0] checkpoint_payload;
    } rtpn_item_t;

    typedef struct packed {
        logic [63:0] chunk;
        logic [3:0]  chunk_bytes;
        logic        last;
        logic        chapter_empty;
        logic        parent_s_clear;
        logic [7:0]  note_count;
    } rtpn_result_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_CMP  = 2'd1,
        CELL_UPD  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t        cmd;
        logic [6:0]       pitch;
        logic [6:0]       vel;
        logic [CNT_W-1:0] count;
        logic             shift_en;
        logic [CNT_W-1:0] shift_from;
        logic [CNT_W-1:0] wpos;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        PK_NONE  = 3'd0,
        PK_TWO   = 3'd1,
        PK_ONE   = 3'd2,
        PK_FINAL = 3'd3,
        PK_EMPTY = 3'd4
    } pk_kind_t;

    typedef struct packed {
        pk_kind_t   kind;
        logic [7:0] b0;
        logic [7:0] b1;
    } pk_req_t;

    typedef struct packed {
        logic       parent;
        logic [7:0] note_count;
    } pk_meta_t;

endpackage

// File: hw/rtl/rtp_midi_note_journal_chapter.sv
// Top level of the note journal chapter block: control, cell row and packer.
// Depends on rtpn_pkg, rtpn_cell and rtpn_packer.
//
//   channel   direction  handshake                    beat
//   item      in         item_valid / item_stall      one note, reset or build command
//   result    out        result_valid / result_stall  one 64-bit chapter chunk
//
// A note on or off passes through the beat, a compare in every cell, an
// encode of the matching cell and a shift-and-append along the row.
// A history reset is done by the beat alone.
// A build rotates the row through all HISTORY_DEPTH cells for statistics and,
// unless the chapter is empty, again for the note logs, then sends one bitfield
// octet a cycle from the LOW to the HIGH octet while the packer takes each one.
// Reset empties the history; the cell contents need no clearing.
// A stalled result pauses the rotation whenever another chunk must go out.
module rtp_midi_note_journal_chapter
    import rtpn_pkg::*;
#(
    parameter int HISTORY_DEPTH = 128,
    parameter int PAYLOAD_BITS  = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  rtpn_item_t   item,
    output logic         result_valid,
    input  logic         result_stall,
    output rtpn_result_t result
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HISTORY_DEPTH);
    localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(HISTORY_DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_N_CMP,
        ST_N_ENC,
        ST_N_UPD,
        ST_B_STAT,
        ST_B_HDR,
        ST_B_LOG,
        ST_B_BF,
        ST_B_END
    } state_t;

    state_t                  state_reg;
    logic [PAYLOAD_BITS-1:0] cur_reg, chk_reg, prev;
    logic [6:0]              pitch_reg, vel_reg;
    logic [CNT_W-1:0]        count_reg, step_reg, idx_reg, len_reg;
    logic                    found_reg, any_off_reg, parent_reg;
    logic [3:0]              low_reg, high_reg, oct_reg;
    logic [15:0][7:0]        off_reg;

    // Cell row. Each cell takes its right neighbour's entry; the last wraps to
    // the first so that a full rotation restores the order.
    logic [6:0]              c_pitch [HISTORY_DEPTH];
    logic [6:0]              c_vel   [HISTORY_DEPTH];
    logic [PAYLOAD_BITS-1:0] c_pay   [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] c_match;
    cell_ctrl_t              ctrl;

    genvar g;
    generate
        for (g = 0; g < HISTORY_DEPTH; g++)
        begin : g_cell
            localparam int RIGHT = (g == HISTORY_DEPTH - 1) ? 0 : g + 1;
            rtpn_cell #(
                .INDEX (g),
                .PAY_W (PAYLOAD_BITS)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .new_pay  (cur_reg),
                .nb_pitch (c_pitch[RIGHT]),
                .nb_vel   (c_vel[RIGHT]),
                .nb_pay   (c_pay[RIGHT]),
                .pitch    (c_pitch[g]),
                .vel      (c_vel[g]),
                .pay      (c_pay[g]),
                .match    (c_match[g])
            );
        end
    endgenerate

    // During a build the head cell shows each entry in turn, oldest first.
    logic [6:0]              head_pitch, head_vel;
    logic [PAYLOAD_BITS-1:0] head_pay;
    logic                    head_live, walked, log_here, advance, chapter_empty;
    logic                    found_c;
    logic [CNT_W-1:0]        idx_c;
    logic                    accept;
    pk_req_t                 req;
    pk_meta_t                meta;
    logic                    taken;

    assign head_pitch    = c_pitch[0];
    assign head_vel      = c_vel[0];
    assign head_pay      = c_pay[0];
    assign prev          = cur_reg - PAYLOAD_BITS'(1);
    assign head_live     = step_reg < count_reg;
    assign walked        = head_live && (head_pay >= chk_reg);
    assign log_here      = walked && (head_vel != 7'd0);
    assign advance       = !log_here || taken;
    assign chapter_empty = (len_reg == '0) && !any_off_reg;
    assign accept        = item_valid && !item_stall;
    assign item_stall    = state_reg != ST_IDLE;

    // Only one cell can match, so the OR of the matching indices is the index.
    always_comb
    begin
        found_c = 1'b0;
        idx_c   = '0;
        for (int k = 0; k < HISTORY_DEPTH; k++)
        begin
            if (c_match[k])
            begin
                found_c = 1'b1;
                idx_c   = idx_c | CNT_W'(k);
            end
        end
    end

    always_comb
    begin
        ctrl            = '0;
        ctrl.cmd        = CELL_HOLD;
        ctrl.pitch      = pitch_reg;
        ctrl.vel        = vel_reg;
        ctrl.count      = count_reg;
        ctrl.wpos       = count_reg;
        unique case (state_reg)
            ST_N_CMP:
            begin
                ctrl.cmd = CELL_CMP;
            end
            ST_N_UPD:
            begin
                ctrl.cmd = CELL_UPD;
                if (found_reg)
                begin
                    // Close the gap of the old entry for this pitch.
                    ctrl.shift_en   = 1'b1;
                    ctrl.shift_from = idx_reg;
                    ctrl.wpos       = count_reg - CNT_W'(1);
                end
                else if (count_reg == DEPTH_C)
                begin
                    // History full: the oldest entry falls off.
                    ctrl.shift_en   = 1'b1;
                    ctrl.shift_from = '0;
                    ctrl.wpos       = LAST_C;
                end
            end
            ST_B_STAT:
            begin
                ctrl.cmd = CELL_ROT;
            end
            ST_B_LOG:
            begin
                if (advance)
                begin
                    ctrl.cmd = CELL_ROT;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        req.kind = PK_NONE;
        req.b0   = '0;
        req.b1   = '0;
        unique case (state_reg)
            ST_B_HDR:
            begin
                // An empty chapter carries no header bytes.
                req.kind = chapter_empty ? PK_NONE : PK_TWO;
                req.b0   = {!parent_reg, (len_reg >= CNT_W'(LEN_MAX)) ? LEN_MAX : len_reg[6:0]};
                req.b1   = {low_reg, high_reg};
            end
            ST_B_LOG:
            begin
                if (log_here)
                begin
                    req.kind = PK_TWO;
                    req.b0   = ((head_pay == prev) ? 8'h00 : LOG_MARK) | {1'b0, head_pitch};
                    req.b1   = LOG_MARK | {1'b0, head_vel};
                end
            end
            ST_B_BF:
            begin
                req.kind = PK_ONE;
                req.b0   = off_reg[oct_reg];
            end
            ST_B_END:
            begin
                req.kind = chapter_empty ? PK_EMPTY : PK_FINAL;
            end
            default:
            begin
            end
        endcase
        meta.parent     = parent_reg;
        meta.note_count = len_reg;
    end

    rtpn_packer u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .meta         (meta),
        .taken        (taken),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        pitch_reg <= item.pitch;
                        vel_reg   <= item.velocity;
                        cur_reg   <= item.current_payload[PAYLOAD_BITS-1:0];
                        chk_reg   <= item.checkpoint_payload[PAYLOAD_BITS-1:0];
                        unique case (op_t'(item.operation))
                            OP_NOTE_ON:
                            begin
                                state_reg <= ST_N_CMP;
                            end
                            OP_NOTE_OFF:
                            begin
                                vel_reg   <= 7'd0;
                                state_reg <= ST_N_CMP;
                            end
                            OP_RESET:
                            begin
                                count_reg <= '0;
                            end
                            OP_BUILD:
                            begin
                                step_reg    <= '0;
                                len_reg     <= '0;
                                low_reg     <= NO_LOW;
                                high_reg    <= 4'd0;
                                any_off_reg <= 1'b0;
                                parent_reg  <= 1'b0;
                                off_reg     <= '0;
                                state_reg   <= ST_B_STAT;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_N_CMP:
                begin
                    state_reg <= ST_N_ENC;
                end
                ST_N_ENC:
                begin
                    found_reg <= found_c;
                    idx_reg   <= idx_c;
                    state_reg <= ST_N_UPD;
                end
                ST_N_UPD:
                begin
                    if (!found_reg && (count_reg != DEPTH_C))
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    state_reg <= ST_IDLE;
                end
                ST_B_STAT:
                begin
                    if (walked)
                    begin
                        if (head_pay == prev)
                        begin
                            parent_reg <= 1'b1;
                        end
                        if (head_vel != 7'd0)
                        begin
                            len_reg <= len_reg + CNT_W'(1);
                        end
                        else
                        begin
                            any_off_reg <= 1'b1;
                            off_reg[head_pitch[6:3]][3'd7 - head_pitch[2:0]] <= 1'b1;
                            if (head_pitch[6:3] < low_reg)
                            begin
                                low_reg <= head_pitch[6:3];
                            end
                            if (head_pitch[6:3] > high_reg)
                            begin
                                high_reg <= head_pitch[6:3];
                            end
                        end
                    end
                    if (step_reg == LAST_C)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_B_HDR;
                    end
                    else
                    begin
                        step_reg <= step_reg + CNT_W'(1);
                    end
                end
                ST_B_HDR:
                begin
                    // An empty chapter sends its single flag beat instead.
                    if (chapter_empty)
                    begin
                        state_reg <= ST_B_END;
                    end
                    else if (taken)
                    begin
                        state_reg <= ST_B_LOG;
                    end
                end
                ST_B_LOG:
                begin
                    if (advance)
                    begin
                        if (step_reg == LAST_C)
                        begin
                            step_reg  <= '0;
                            oct_reg   <= low_reg;
                            state_reg <= any_off_reg ? ST_B_BF : ST_B_END;
                        end
                        else
                        begin
                            step_reg <= step_reg + CNT_W'(1);
                        end
                    end
                end
                ST_B_BF:
                begin
                    if (taken)
                    begin
                        if (oct_reg == high_reg)
                        begin
                            state_reg <= ST_B_END;
                        end
                        else
                        begin
                            oct_reg <= oct_reg + 4'd1;
                        end
                    end
                end
                ST_B_END:
                begin
                    if (taken)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // The history never holds more entries than there are cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("history count beyond depth");

    // An empty-chapter beat carries no bytes and closes the chapter.
    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.chapter_empty) |-> (result.last && result.chunk_bytes == 4'd0))
        else $error("empty chapter beat malformed");

    // Note updates never reach the output.
    a_note_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_N_CMP || state_reg == ST_N_ENC || state_reg == ST_N_UPD)
        |-> (req.kind == PK_NONE))
        else $error("packer request during a note update");

    // The rotation step never runs beyond the last cell of the row.
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= LAST_C)
        else $error("rotation step beyond the row");
`endif

endmodule

// File: hw/rtl/rtpn_cell.sv
// One history cell: holds a single entry and passes it to its left neighbour.
// Depends on rtpn_pkg for the broadcast control struct.
module rtpn_cell
    import rtpn_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int PAY_W = 32
)
(
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic [PAY_W-1:0] new_pay,
    input  logic [6:0]       nb_pitch,
    input  logic [6:0]       nb_vel,
    input  logic [PAY_W-1:0] nb_pay,
    output logic [6:0]       pitch,
    output logic [6:0]       vel,
    output logic [PAY_W-1:0] pay,
    output logic             match
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [6:0]       pitch_reg;
    logic [6:0]       vel_reg;
    logic [PAY_W-1:0] pay_reg;
    logic             match_reg;

    always_ff @(posedge clk)
    begin
        unique case (ctrl.cmd)
            CELL_CMP:
            begin
                match_reg <= (MY_IDX < ctrl.count) && (pitch_reg == ctrl.pitch);
            end
            CELL_UPD:
            begin
                // The new entry lands at wpos while the gap closes in the same update.
                if (MY_IDX == ctrl.wpos)
                begin
                    pitch_reg <= ctrl.pitch;
                    vel_reg   <= ctrl.vel;
                    pay_reg   <= new_pay;
                end
                else if (ctrl.shift_en && (MY_IDX >= ctrl.shift_from))
                begin
                    pitch_reg <= nb_pitch;
                    vel_reg   <= nb_vel;
                    pay_reg   <= nb_pay;
                end
            end
            CELL_ROT:
            begin
                pitch_reg <= nb_pitch;
                vel_reg   <= nb_vel;
                pay_reg   <= nb_pay;
            end
            default:
            begin
            end
        endcase
    end

    assign pitch = pitch_reg;
    assign vel   = vel_reg;
    assign pay   = pay_reg;
    assign match = match_reg;

endmodule

// File: hw/rtl/rtpn_packer.sv
// Byte packer and output register: gathers chapter bytes into 64-bit chunks.
// Depends on rtpn_pkg for the request, meta and result types.
module rtpn_packer
    import rtpn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  pk_req_t      req,
    input  pk_meta_t     meta,
    output logic         taken,
    output logic         result_valid,
    input  logic         result_stall,
    output rtpn_result_t result
);

    logic [63:0]  word_reg, word_next;
    logic [3:0]   fill_reg, fill_next;
    logic         valid_reg, valid_next;
    rtpn_result_t res_reg, res_next;
    logic         can_load;
    logic         load;

    assign can_load = !valid_reg || !result_stall;

    always_comb
    begin
        taken     = 1'b0;
        load      = 1'b0;
        word_next = word_reg;
        fill_next = fill_reg;
        res_next  = res_reg;
        res_next.chunk          = word_reg;
        res_next.chunk_bytes    = fill_reg;
        res_next.last           = 1'b0;
        res_next.chapter_empty  = 1'b0;
        res_next.parent_s_clear = meta.parent;
        res_next.note_count     = meta.note_count;
        case (req.kind)
            PK_TWO, PK_ONE:
            begin
                if (fill_reg == CHUNK_FULL)
                begin
                    // A full chunk goes out before any further byte is added.
                    if (can_load)
                    begin
                        load      = 1'b1;
                        word_next = 64'd0;
                        fill_next = 4'd0;
                    end
                end
                else if (req.kind == PK_TWO)
                begin
                    word_next = word_reg | (64'({req.b0, req.b1})
                                << (7'd48 - {fill_reg, 3'b000}));
                    fill_next = fill_reg + 4'd2;
                    taken     = 1'b1;
                end
                else
                begin
                    word_next = word_reg | (64'(req.b0) << (7'd56 - {fill_reg, 3'b000}));
                    fill_next = fill_reg + 4'd1;
                    taken     = 1'b1;
                end
            end
            PK_FINAL:
            begin
                if (can_load)
                begin
                    load          = 1'b1;
                    res_next.last = 1'b1;
                    word_next     = 64'd0;
                    fill_next     = 4'd0;
                    taken         = 1'b1;
                end
            end
            PK_EMPTY:
            begin
                if (can_load)
                begin
                    load                    = 1'b1;
                    res_next.chunk          = 64'd0;
                    res_next.chunk_bytes    = 4'd0;
                    res_next.last           = 1'b1;
                    res_next.chapter_empty  = 1'b1;
                    res_next.parent_s_clear = 1'b0;
                    res_next.note_count     = 8'd0;
                    taken                   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        valid_next = load ? 1'b1 : (valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= 64'd0;
            fill_reg  <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            word_reg  <= word_next;
            fill_reg  <= fill_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = res_reg;

endmodule
